// File: src/pfe_pkg.sv
// Package with the shared types and constants of the protobuf field extractor.
`default_nettype none
package pfe_pkg;

    localparam int unsigned FieldNumWidth = 29;
    localparam int unsigned VarintWidth   = 64;
    localparam int unsigned ShiftWidth    = 7;
    localparam int unsigned CfgIndexWidth = 2;

    localparam logic [ShiftWidth-1:0] VarintStep = 7'd7;

    localparam logic [FieldNumWidth-1:0] SourceReset    = 29'd2;
    localparam logic [FieldNumWidth-1:0] NamespaceReset = 29'd4;
    localparam logic [FieldNumWidth-1:0] PayloadReset   = 29'd6;

    typedef enum logic [CfgIndexWidth-1:0] {
        CFG_SOURCE    = 2'd0,
        CFG_NAMESPACE = 2'd1,
        CFG_PAYLOAD   = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        WT_VARINT = 3'd0,
        WT_LENGTH = 3'd2
    } wire_type_t;

    typedef enum logic [1:0] {
        CLASS_STRUCT  = 2'd0,
        CLASS_CONTENT = 2'd1,
        CLASS_SKIPPED = 2'd2,
        CLASS_STOPPED = 2'd3
    } byte_class_t;

    typedef enum logic [1:0] {
        FIELD_NONE      = 2'd0,
        FIELD_SOURCE    = 2'd1,
        FIELD_NAMESPACE = 2'd2,
        FIELD_PAYLOAD   = 2'd3
    } field_id_t;

    typedef enum logic [5:0] {
        PH_TAG     = 6'b000001,
        PH_VSKIP   = 6'b000010,
        PH_LEN     = 6'b000100,
        PH_CFIRST  = 6'b001000,
        PH_CONTENT = 6'b010000,
        PH_STOP    = 6'b100000
    } phase_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        byte_class_t byte_class;
        field_id_t   field_id;
        logic        value_start;
        logic        value_end;
        logic        stopped;
        logic        message_end;
    } result_t;

endpackage
`default_nettype wire

// File: src/pfe_cfg.sv
// Field number registers and the tag matcher with source-first priority.
`default_nettype none
module pfe_cfg (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_we,
    input  wire logic [pfe_pkg::CfgIndexWidth-1:0]     cfg_index,
    input  wire logic [pfe_pkg::FieldNumWidth-1:0]     cfg_data,
    input  wire logic [pfe_pkg::VarintWidth-1:0]       tag_value,
    output pfe_pkg::field_id_t                         match_id
);
    import pfe_pkg::*;

    logic [FieldNumWidth-1:0] source_reg;
    logic [FieldNumWidth-1:0] namespace_reg;
    logic [FieldNumWidth-1:0] payload_reg;
    logic                     upper_zero;
    logic [FieldNumWidth-1:0] field_num;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_reg    <= SourceReset;
            namespace_reg <= NamespaceReset;
            payload_reg   <= PayloadReset;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SOURCE:    source_reg    <= cfg_data;
                CFG_NAMESPACE: namespace_reg <= cfg_data;
                CFG_PAYLOAD:   payload_reg   <= cfg_data;
                default:       ;
            endcase
        end
    end

    // A field number wider than the registers never matches.
    assign upper_zero = (tag_value[VarintWidth-1:FieldNumWidth+3] == '0);
    assign field_num  = tag_value[FieldNumWidth+2:3];

    always_comb
    begin
        match_id = FIELD_NONE;
        if (upper_zero)
        begin
            if (field_num == source_reg)
                match_id = FIELD_SOURCE;
            else if (field_num == namespace_reg)
                match_id = FIELD_NAMESPACE;
            else if (field_num == payload_reg)
                match_id = FIELD_PAYLOAD;
        end
    end

endmodule
`default_nettype wire

// File: src/pfe_parser.sv
// Wire format state machine: varint decoding, length tracking and byte marking.
`default_nettype none
module pfe_parser (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            advance,
    input  wire logic [7:0]                      data_byte,
    input  wire logic                            last_byte,
    input  wire pfe_pkg::field_id_t              match_id,
    output logic [pfe_pkg::VarintWidth-1:0]      tag_value,
    output pfe_pkg::result_t                     result
);
    import pfe_pkg::*;

    phase_t                  phase_reg, phase_next;
    logic [VarintWidth-1:0]  acc_reg, acc_next;
    logic [ShiftWidth-1:0]   shift_reg, shift_next;
    logic [VarintWidth-1:0]  remain_reg, remain_next;
    field_id_t               field_reg, field_next;

    logic [VarintWidth-1:0]  absorbed;
    logic [ShiftWidth-1:0]   shift_inc;
    logic                    more;

    // Once the shift reaches 64 or more the incoming bits are dropped and it stops growing.
    always_comb
    begin
        absorbed = acc_reg;
        if (!shift_reg[ShiftWidth-1])
            absorbed = acc_reg | ({{(VarintWidth-7){1'b0}}, data_byte[6:0]}
                                  << shift_reg[ShiftWidth-2:0]);
        shift_inc = shift_reg[ShiftWidth-1] ? shift_reg : shift_reg + VarintStep;
    end

    assign more      = data_byte[7];
    assign tag_value = absorbed;

    always_comb
    begin
        phase_next  = phase_reg;
        acc_next    = acc_reg;
        shift_next  = shift_reg;
        remain_next = remain_reg;
        field_next  = field_reg;

        result.out_byte    = data_byte;
        result.byte_class  = CLASS_STRUCT;
        result.field_id    = FIELD_NONE;
        result.value_start = 1'b0;
        result.value_end   = 1'b0;
        result.stopped     = 1'b0;
        result.message_end = last_byte;

        case (phase_reg)
            PH_TAG:
            begin
                if (more && !last_byte)
                begin
                    acc_next   = absorbed;
                    shift_next = shift_inc;
                end
                else
                begin
                    acc_next   = '0;
                    shift_next = '0;
                    if (absorbed[2:0] == WT_VARINT)
                        phase_next = PH_VSKIP;
                    else if (absorbed[2:0] == WT_LENGTH)
                    begin
                        field_next = match_id;
                        phase_next = PH_LEN;
                        if (last_byte && match_id != FIELD_NONE)
                        begin
                            result.field_id    = match_id;
                            result.value_start = 1'b1;
                            result.value_end   = 1'b1;
                        end
                    end
                    else
                    begin
                        phase_next     = PH_STOP;
                        result.stopped = 1'b1;
                    end
                end
            end
            PH_VSKIP:
            begin
                result.byte_class = CLASS_SKIPPED;
                if (!more)
                    phase_next = PH_TAG;
            end
            PH_LEN:
            begin
                if (more && !last_byte)
                begin
                    acc_next   = absorbed;
                    shift_next = shift_inc;
                end
                else
                begin
                    acc_next   = '0;
                    shift_next = '0;
                    if (last_byte || absorbed == '0)
                    begin
                        // Empty value: start and end on the final length byte.
                        if (field_reg != FIELD_NONE)
                        begin
                            result.field_id    = field_reg;
                            result.value_start = 1'b1;
                            result.value_end   = 1'b1;
                        end
                        phase_next = PH_TAG;
                    end
                    else
                    begin
                        remain_next = absorbed;
                        phase_next  = PH_CFIRST;
                    end
                end
            end
            PH_CFIRST, PH_CONTENT:
            begin
                result.byte_class  = (field_reg != FIELD_NONE) ? CLASS_CONTENT
                                                                : CLASS_SKIPPED;
                result.field_id    = field_reg;
                result.value_start = (phase_reg == PH_CFIRST) && (field_reg != FIELD_NONE);
                remain_next        = remain_reg - {{(VarintWidth-1){1'b0}}, 1'b1};
                if (remain_reg == {{(VarintWidth-1){1'b0}}, 1'b1} || last_byte)
                begin
                    result.value_end = (field_reg != FIELD_NONE);
                    phase_next       = PH_TAG;
                end
                else
                    phase_next = PH_CONTENT;
            end
            PH_STOP:
            begin
                result.byte_class = CLASS_STOPPED;
                result.stopped    = 1'b1;
            end
            default:
            begin
                phase_next = PH_TAG;
            end
        endcase

        // The message end returns all parse state to its reset value.
        if (last_byte)
        begin
            phase_next  = PH_TAG;
            acc_next    = '0;
            shift_next  = '0;
            remain_next = '0;
            field_next  = FIELD_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_TAG;
            acc_reg    <= '0;
            shift_reg  <= '0;
            remain_reg <= '0;
            field_reg  <= FIELD_NONE;
        end
        else if (advance)
        begin
            phase_reg  <= phase_next;
            acc_reg    <= acc_next;
            shift_reg  <= shift_next;
            remain_reg <= remain_next;
            field_reg  <= field_next;
        end
    end

endmodule
`default_nettype wire

// File: src/protobuf_field_extractor.sv
// Top level of the protobuf field extractor: stream handshakes and pipeline registers.
// Path: an accepted item waits in the input register and moves into the result register
// once that register is empty or being drained, and its result is then offered.
// Throughput: one item per cycle; a single stage of logic sits between the input
// register and the result register, and a stalled output holds the input back.
// Reset: rst_n clears the valids and the parse state and loads field numbers 2, 4 and 6.
`default_nettype none
module protobuf_field_extractor (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,

    // Input stream. tdata: data_byte[7:0]. tlast: last_byte.
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    input  wire logic [7:0]                           s_axis_tdata,
    input  wire logic                                 s_axis_tlast,

    // Result stream. tdata: out_byte[7:0]. tlast: message_end.
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    output logic [7:0]                                m_axis_tdata,
    // tuser: byte_class[1:0], field_id[3:2], value_start[4], value_end[5], stopped[6].
    output logic [6:0]                                m_axis_tuser,
    output logic                                      m_axis_tlast,

    // Configuration writes: source, namespace and payload field numbers.
    input  wire logic                                 cfg_we,
    input  wire logic [pfe_pkg::CfgIndexWidth-1:0]    cfg_index,
    input  wire logic [pfe_pkg::FieldNumWidth-1:0]    cfg_data
);
    import pfe_pkg::*;

    logic                    in_valid_reg;
    logic [7:0]              in_byte_reg;
    logic                    in_last_reg;
    logic                    out_valid_reg;
    result_t                 out_reg;
    logic                    advance;
    logic [VarintWidth-1:0]  tag_value;
    field_id_t               match_id;
    result_t                 result;

    // The input register moves forward whenever the result register is empty or
    // being drained, so the block keeps taking an item each cycle while the
    // downstream side keeps up.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    pfe_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .tag_value (tag_value),
        .match_id  (match_id)
    );

    pfe_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .data_byte (in_byte_reg),
        .last_byte (in_last_reg),
        .match_id  (match_id),
        .tag_value (tag_value),
        .result    (result)
    );

    // The result register holds an item until the downstream side takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= result;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg.out_byte;
    assign m_axis_tuser  = {out_reg.stopped, out_reg.value_end, out_reg.value_start,
                            out_reg.field_id, out_reg.byte_class};
    assign m_axis_tlast  = out_reg.message_end;

endmodule
`default_nettype wire

// File: test/protobuf_field_extractor_tb.sv
// Self-checking testbench for the protobuf field extractor: scoreboard, drivers, stimulus.
module protobuf_field_extractor_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pfe_pkg::*;

    // Scoreboard: tracks the wire format state the same way the block does and
    // holds one expected result per accepted byte, oldest first.
    class field_extract_scoreboard;
        logic [FieldNumWidth-1:0] field_num [3];
        phase_t                   parse_phase;
        logic [VarintWidth-1:0]   varint_acc;
        logic [ShiftWidth-1:0]    shift_bits;
        logic [VarintWidth-1:0]   bytes_left;
        field_id_t                cur_field;
        result_t                  expected_results [$];
        int                       error_count;

        function new();
            field_num[CFG_SOURCE]    = SourceReset;
            field_num[CFG_NAMESPACE] = NamespaceReset;
            field_num[CFG_PAYLOAD]   = PayloadReset;
            error_count = 0;
            clear_parse();
        endfunction

        function void clear_parse();
            parse_phase = PH_TAG;
            varint_acc  = '0;
            shift_bits  = '0;
            bytes_left  = '0;
            cur_field   = FIELD_NONE;
        endfunction

        function void set_field(cfg_index_t idx, logic [FieldNumWidth-1:0] value);
            field_num[idx] = value;
        endfunction

        // Adds the low seven bits of a byte at the current shift; anything past
        // bit 63 is lost.
        function logic [VarintWidth-1:0] absorb(logic [7:0] d);
            if (shift_bits < 7'd64)
            begin
                return varint_acc | ({57'd0, d[6:0]} << shift_bits);
            end
            return varint_acc;
        endfunction

        // Source beats namespace, namespace beats payload. Numbers wider than
        // 29 bits can never compare equal.
        function field_id_t match_field(logic [VarintWidth-1:0] f);
            if (f == 64'(field_num[CFG_SOURCE]))
            begin
                return FIELD_SOURCE;
            end
            if (f == 64'(field_num[CFG_NAMESPACE]))
            begin
                return FIELD_NAMESPACE;
            end
            if (f == 64'(field_num[CFG_PAYLOAD]))
            begin
                return FIELD_PAYLOAD;
            end
            return FIELD_NONE;
        endfunction

        // An empty value of a selected field starts and ends on one byte.
        function result_t with_empty_value(result_t r);
            if (cur_field != FIELD_NONE)
            begin
                r.field_id    = cur_field;
                r.value_start = 1'b1;
                r.value_end   = 1'b1;
            end
            return r;
        endfunction

        function result_t decode_byte(logic [7:0] d, logic last);
            result_t                r;
            logic [VarintWidth-1:0] v;
            logic                   more;
            more          = d[7];
            v             = '0;
            r.out_byte    = d;
            r.byte_class  = CLASS_STRUCT;
            r.field_id    = FIELD_NONE;
            r.value_start = 1'b0;
            r.value_end   = 1'b0;
            r.stopped     = 1'b0;
            r.message_end = last;
            case (parse_phase)
                PH_TAG, PH_LEN:
                begin
                    v = absorb(d);
                    if (more && !last)
                    begin
                        varint_acc = v;
                        if (shift_bits < 7'd64)
                        begin
                            shift_bits = shift_bits + VarintStep;
                        end
                    end
                    else
                    begin
                        varint_acc = '0;
                        shift_bits = '0;
                        if (parse_phase == PH_TAG)
                        begin
                            if (v[2:0] == WT_VARINT)
                            begin
                                parse_phase = PH_VSKIP;
                            end
                            else if (v[2:0] == WT_LENGTH)
                            begin
                                cur_field   = match_field(v >> 3);
                                parse_phase = PH_LEN;
                                if (last)
                                begin
                                    r = with_empty_value(r);
                                end
                            end
                            else
                            begin
                                parse_phase = PH_STOP;
                                r.stopped   = 1'b1;
                            end
                        end
                        else if (last || v == '0)
                        begin
                            r = with_empty_value(r);
                            parse_phase = PH_TAG;
                        end
                        else
                        begin
                            bytes_left  = v;
                            parse_phase = PH_CFIRST;
                        end
                    end
                end
                PH_VSKIP:
                begin
                    r.byte_class = CLASS_SKIPPED;
                    if (!more)
                    begin
                        parse_phase = PH_TAG;
                    end
                end
                PH_CFIRST, PH_CONTENT:
                begin
                    r.byte_class  = (cur_field != FIELD_NONE) ? CLASS_CONTENT : CLASS_SKIPPED;
                    r.field_id    = cur_field;
                    r.value_start = (parse_phase == PH_CFIRST) && (cur_field != FIELD_NONE);
                    bytes_left    = bytes_left - 64'd1;
                    if (bytes_left == '0 || last)
                    begin
                        r.value_end = (cur_field != FIELD_NONE);
                        parse_phase = PH_TAG;
                    end
                    else
                    begin
                        parse_phase = PH_CONTENT;
                    end
                end
                PH_STOP:
                begin
                    r.byte_class = CLASS_STOPPED;
                    r.stopped    = 1'b1;
                end
                default:
                begin
                    parse_phase = PH_TAG;
                end
            endcase
            // The last byte of a message puts the parser back to its idle state.
            if (last)
            begin
                clear_parse();
            end
            return r;
        endfunction

        function void note_byte(logic [7:0] d, logic last);
            expected_results.push_back(decode_byte(d, last));
        endfunction

        function void check_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want)
            begin
                $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
                error_count++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_results.size() == 0)
            begin
                $error("result with no byte pending: out_byte 0x%0h", got.out_byte);
                error_count++;
                return;
            end
            want = expected_results.pop_front();
            check_field("out_byte", want.out_byte, got.out_byte);
            check_field("byte_class", 8'(want.byte_class), 8'(got.byte_class));
            check_field("field_id", 8'(want.field_id), 8'(got.field_id));
            check_field("value_start", 8'(want.value_start), 8'(got.value_start));
            check_field("value_end", 8'(want.value_end), 8'(got.value_end));
            check_field("stopped", 8'(want.stopped), 8'(got.stopped));
            check_field("message_end", 8'(want.message_end), 8'(got.message_end));
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n         = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [7:0]               s_axis_tdata  = '0;
    logic                     s_axis_tlast  = 1'b0;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [7:0]               m_axis_tdata;
    logic [6:0]               m_axis_tuser;
    logic                     m_axis_tlast;
    logic                     cfg_we        = 1'b0;
    logic [CfgIndexWidth-1:0] cfg_index     = '0;
    logic [FieldNumWidth-1:0] cfg_data      = '0;

    field_extract_scoreboard sb;

    // Message bytes under construction; sent and then cleared.
    logic [7:0] msg_bytes [$];

    // Idle rates in percent for the sender and the receiver, and a hold-off
    // count that the receiver process consumes one cycle at a time.
    int send_idle_pct   = 0;
    int stall_pct       = 0;
    int hold_off_cycles = 0;
    int phase_items     = 0;

    protobuf_field_extractor u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the handshake hangs; far beyond the slowest legal run.
    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Offers one byte, possibly after some idle cycles, and returns at the edge
    // where it was taken. Called only at a rising edge, so the valid is set at
    // most once per time step.
    task automatic send_byte(logic [7:0] d, logic last);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        sb.note_byte(d, last);
        phase_items++;
    endtask

    // Sends the first count bytes of the message; the last of them ends it.
    task automatic send_message(int count);
        for (int i = 0; i < count; i++)
        begin
            send_byte(msg_bytes[i], i == count - 1);
        end
        msg_bytes.delete();
    endtask

    // Drops the valid and waits for every pending result, then a few more
    // cycles to cover the two-stage pipeline.
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // Writes all three field numbers on consecutive edges; the block is idle.
    task automatic write_field_numbers(logic [FieldNumWidth-1:0] src,
                                       logic [FieldNumWidth-1:0] ns,
                                       logic [FieldNumWidth-1:0] pl);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SOURCE;
        cfg_data  <= src;
        sb.set_field(CFG_SOURCE, src);
        @(posedge clk);
        cfg_index <= CFG_NAMESPACE;
        cfg_data  <= ns;
        sb.set_field(CFG_NAMESPACE, ns);
        @(posedge clk);
        cfg_index <= CFG_PAYLOAD;
        cfg_data  <= pl;
        sb.set_field(CFG_PAYLOAD, pl);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic void push_varint(logic [63:0] v);
        while (v > 64'd127)
        begin
            msg_bytes.push_back({1'b1, v[6:0]});
            v = v >> 7;
        end
        msg_bytes.push_back({1'b0, v[6:0]});
    endfunction

    function automatic void push_tag(logic [60:0] fn, logic [2:0] wt);
        push_varint({fn, wt});
    endfunction

    function automatic void push_random_bytes(int count);
        repeat (count) msg_bytes.push_back(8'($urandom));
    endfunction

    // Mostly one of the configured numbers, otherwise a small number that may
    // or may not hit one of them.
    function automatic logic [60:0] pick_field_number();
        case ($urandom_range(0, 4))
            0:       return 61'(sb.field_num[CFG_SOURCE]);
            1:       return 61'(sb.field_num[CFG_NAMESPACE]);
            2:       return 61'(sb.field_num[CFG_PAYLOAD]);
            default: return 61'($urandom_range(0, 15));
        endcase
    endfunction

    // One random message: mostly well-formed fields with random content,
    // some cut short at a random byte, and some plain noise.
    task automatic send_random_message();
        int          form;
        int          len;
        int          cut;
        logic [2:0]  wt;
        logic [60:0] fn;
        form = $urandom_range(0, 99);
        if (form < 8)
        begin
            push_random_bytes($urandom_range(1, 6));
            send_message(msg_bytes.size());
        end
        else
        begin
            repeat ($urandom_range(1, 5))
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3:
                    begin
                        // Length-delimited field, short content most of the time.
                        push_tag(pick_field_number(), WT_LENGTH);
                        len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40)
                                                          : $urandom_range(0, 6);
                        push_varint(64'(len));
                        push_random_bytes(len);
                    end
                    4, 5:
                    begin
                        // Varint field with a value of random size.
                        push_tag(pick_field_number(), WT_VARINT);
                        push_varint({$urandom, $urandom} >> $urandom_range(0, 63));
                    end
                    6:
                    begin
                        // Length varint running past bit 63; the huge length
                        // means the content is cut short by the message end.
                        push_tag(pick_field_number(), WT_LENGTH);
                        repeat ($urandom_range(9, 12)) msg_bytes.push_back({1'b1, 7'($urandom)});
                        msg_bytes.push_back({1'b0, 7'($urandom)});
                        push_random_bytes($urandom_range(0, 5));
                    end
                    7:
                    begin
                        // Field number wider than 29 bits whose low bits may equal
                        // a configured number.
                        fn = pick_field_number() | (61'd1 << $urandom_range(29, 60));
                        push_tag(fn, WT_LENGTH);
                        len = $urandom_range(0, 4);
                        push_varint(64'(len));
                        push_random_bytes(len);
                    end
                    8:
                    begin
                        // Unsupported wire type: the rest of the message is ignored.
                        do
                        begin
                            wt = 3'($urandom);
                        end
                        while (wt == WT_VARINT || wt == WT_LENGTH);
                        push_tag(pick_field_number(), wt);
                        push_random_bytes($urandom_range(0, 4));
                    end
                    default:
                    begin
                        fn = 61'({$urandom, $urandom} >> $urandom_range(3, 60));
                        push_tag(fn, WT_LENGTH);
                        len = $urandom_range(1, 3);
                        push_varint(64'(len));
                        push_random_bytes(len);
                    end
                endcase
            end
            cut = (form < 20) ? $urandom_range(1, msg_bytes.size()) : msg_bytes.size();
            send_message(cut);
        end
    endtask

    // Result side: checks every accepted result and then picks the ready for
    // the next cycle, honoring a pending hold-off first.
    initial
    begin
        result_t got;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.out_byte    = m_axis_tdata;
                got.byte_class  = byte_class_t'(m_axis_tuser[1:0]);
                got.field_id    = field_id_t'(m_axis_tuser[3:2]);
                got.value_start = m_axis_tuser[4];
                got.value_end   = m_axis_tuser[5];
                got.stopped     = m_axis_tuser[6];
                got.message_end = m_axis_tlast;
                sb.check_result(got);
            end
            if (hold_off_cycles > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_off_cycles--;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // Main sequence: reset, directed messages, then random phases that each
    // use their own field numbers and idle rates.
    initial
    begin
        sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Field numbers at their reset values: source 2, namespace 4, payload 6.
        msg_bytes = '{8'h12, 8'h02, 8'h41, 8'h42,   // source, two content bytes
                      8'h22, 8'h00,                 // namespace, empty value
                      8'h08, 8'hAC, 8'h02,          // field 1 varint 300, skipped
                      8'h32, 8'h01, 8'hFF,          // payload, one content byte
                      8'h3A, 8'h01, 8'h00};         // field 7, not selected
        send_message(msg_bytes.size());
        msg_bytes = '{8'h0D, 8'h11, 8'h22};         // fixed32 wire type stops parsing
        send_message(msg_bytes.size());
        msg_bytes = '{8'h12};                       // selected tag on the last byte
        send_message(msg_bytes.size());
        msg_bytes = '{8'h92};                       // tag cut short, decoded as is
        send_message(msg_bytes.size());
        msg_bytes = '{8'h32, 8'h85};                // length cut short
        send_message(msg_bytes.size());
        msg_bytes = '{8'h32, 8'h05, 8'h01};         // content cut short
        send_message(msg_bytes.size());

        // Extremes: field 0 as source, the largest number for both others, so
        // namespace must win over payload.
        wait_for_results();
        write_field_numbers('0, '1, '1);
        msg_bytes = '{8'h02, 8'h01, 8'h55,
                      8'hFA, 8'hFF, 8'hFF, 8'hFF, 8'h0F, 8'h00};
        send_message(msg_bytes.size());

        for (int p = 0; p < 8; p++)
        begin
            wait_for_results();
            case (p)
                0:       write_field_numbers(SourceReset, NamespaceReset, PayloadReset);
                1:       write_field_numbers('0, '1, '1);
                3:       write_field_numbers(29'(p + 2), 29'(p + 2), 29'(p + 2));
                4:       write_field_numbers(29'($urandom), 29'($urandom), 29'($urandom));
                5:       write_field_numbers('1, '0, 29'd1);
                default: write_field_numbers(29'($urandom_range(0, 15)),
                                             29'($urandom_range(0, 15)),
                                             29'($urandom_range(0, 15)));
            endcase
            case (p % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 45;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 45;
                end
                default:
                begin
                    send_idle_pct = 36;
                    stall_pct     = 36;
                end
            endcase
            // In the first phase the receiver holds off for a long stretch while
            // bytes keep coming, so the pipeline fills and the input stalls.
            if (p == 0)
            begin
                hold_off_cycles = 150;
            end
            phase_items = 0;
            while (phase_items < 100)
            begin
                send_random_message();
            end
        end

        wait_for_results();
        repeat (8) @(posedge clk);
        if (sb.error_count == 0 && sb.expected_results.size() == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: protobuf_field_extractor.f
src/pfe_pkg.sv
src/pfe_cfg.sv
src/pfe_parser.sv
src/protobuf_field_extractor.sv
test/protobuf_field_extractor_tb.sv
